// File: rtl/core/aff_inv_pkg.sv
`timescale 1ns / 1ps
// aff_inv_pkg: types and constants shared by the affine 3x4 inverse block.
// No dependencies.
package aff_inv_pkg;

  localparam int NUM_ELEM  = 12;
  localparam int IDX_W     = 4;
  localparam int VAL_W     = 32;
  localparam int TOL_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int ACC_W     = 128;
  localparam int COF_W     = 65;

  localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(NUM_ELEM - 1);

  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_TRANSLATION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DET_TOLERANCE    = 2'd1;

  typedef struct packed {
    logic [IDX_W-1:0]        elem_index;
    logic signed [VAL_W-1:0] elem_value;
  } elem_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]        out_index;
    logic signed [VAL_W-1:0] out_value;
    logic                    singular;
    logic                    saturated;
    logic                    last_out;
  } elem_out_t;

  typedef struct packed {
    logic             keep_translation;
    logic [TOL_W-1:0] det_tolerance;
  } cfg_t;

endpackage

// File: rtl/core/aff_inv_front.sv
`timescale 1ns / 1ps
// aff_inv_front: input side; drops out-of-range indices and queues elements.
// Depends on aff_inv_pkg.
module aff_inv_front import aff_inv_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  elem_in_t in_data,
  output logic     q_valid,
  input  logic     q_ready,
  output elem_in_t q_data
);

  localparam int QD  = 4;
  localparam int QA  = $clog2(QD);

  elem_in_t       mem [QD];
  logic [QA-1:0]  wp;
  logic [QA-1:0]  rp;
  logic [QA:0]    cnt;
  logic           push;
  logic           pop;

  assign in_ready = (cnt != (QA+1)'(QD));
  assign q_valid  = (cnt != '0);
  assign q_data   = mem[rp];
  assign push     = in_valid && in_ready && (in_data.elem_index <= LAST_INDEX);
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      cnt <= cnt + (QA+1)'(push) - (QA+1)'(pop);
    end
  end

endmodule

// File: rtl/core/aff_inv_back.sv
`timescale 1ns / 1ps
// aff_inv_back: element store, cofactor/determinant MAC sequencer, serial divider.
// Depends on aff_inv_pkg.
module aff_inv_back import aff_inv_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      q_valid,
  output logic      q_ready,
  input  elem_in_t  q_data,
  output logic      out_valid,
  input  logic      out_ready,
  output elem_out_t out_data
);

  localparam int DCNT_W = $clog2(ACC_W);

  typedef enum logic [3:0] {
    S_IDLE, S_MAC, S_CHK1, S_CHK2, S_ELEM, S_CPY0, S_CPY1,
    S_DLD, S_DADD, S_DIV, S_DSAT, S_OUT
  } state_t;

  typedef enum logic [1:0] {P_COF, P_DET, P_TRN} prog_t;

  state_t state;
  prog_t  prog;

  logic [VAL_W-1:0]  store [NUM_ELEM];
  logic [IDX_W-1:0]  rd_addr;
  logic [VAL_W-1:0]  rd_data;

  logic [COF_W-1:0]  cof [9];
  logic [3:0]        cof_addr;
  logic [1:0]        cof_row;
  logic [1:0]        cof_col;
  logic [COF_W-1:0]  cof_rd;

  logic [4:0]        op;
  logic [2:0]        ph;
  logic              sub;
  logic [3:0]        c;
  logic [1:0]        t;
  logic [1:0]        r1, r2, c1, c2;
  logic              last_op;
  logic              clear;

  logic signed [VAL_W-1:0] opa;
  logic signed [VAL_W:0]   opb;
  logic signed [65:0]      p;
  logic                    p_sh;
  logic                    p_neg;
  logic [ACC_W-1:0]        pext;
  logic [ACC_W-1:0]        acc_base;
  logic [ACC_W-1:0]        acc_next;
  logic [ACC_W-1:0]        acc;
  logic [ACC_W-1:0]        det;
  logic [ACC_W-1:0]        det_mag;
  logic [ACC_W-1:0]        tol;
  logic                    singular;

  logic [ACC_W-1:0]        src;
  logic [ACC_W-1:0]        mag;
  logic                    j3;
  logic [ACC_W-1:0]        dn;
  logic [ACC_W-1:0]        dq;
  logic [ACC_W-1:0]        dr;
  logic                    dneg;
  logic [DCNT_W-1:0]       dcnt;
  logic [ACC_W:0]          r_sh;
  logic                    r_ge;
  logic [ACC_W-1:0]        limit;
  logic                    over;
  logic [VAL_W-1:0]        mag32;

  logic [IDX_W-1:0]        k;
  logic [VAL_W-1:0]        o_val;
  logic                    o_sat;

  function automatic logic [1:0] nxt3(input logic [1:0] x);
    nxt3 = (x == 2'd2) ? 2'd0 : x + 2'd1;
  endfunction

  // cofactor number -> row i (high) and column j (low) of the cofactor matrix
  function automatic logic [3:0] cof_ij(input logic [3:0] n);
    unique case (n)
      4'd0:    cof_ij = {2'd0, 2'd0};
      4'd1:    cof_ij = {2'd0, 2'd1};
      4'd2:    cof_ij = {2'd0, 2'd2};
      4'd3:    cof_ij = {2'd1, 2'd0};
      4'd4:    cof_ij = {2'd1, 2'd1};
      4'd5:    cof_ij = {2'd1, 2'd2};
      4'd6:    cof_ij = {2'd2, 2'd0};
      4'd7:    cof_ij = {2'd2, 2'd1};
      4'd8:    cof_ij = {2'd2, 2'd2};
      default: cof_ij = {2'd0, 2'd0};
    endcase
  endfunction

  assign sub = op[0];
  assign c   = op[4:1];
  assign t   = op[2:1];
  assign j3  = (k[1:0] == 2'd3);

  always_comb begin
    logic [3:0] ij;
    ij = cof_ij(c);
    r1 = nxt3(ij[1:0]);
    r2 = nxt3(r1);
    c1 = nxt3(ij[3:2]);
    c2 = nxt3(c1);
  end

  assign last_op = (prog == P_COF) ? (op == 5'd17) : (op == 5'd5);
  assign clear   = (op == 5'd0) || ((prog == P_COF) && !sub);

  always_comb begin
    rd_addr = '0;
    if (state == S_MAC) begin
      if (ph == 3'd0) begin
        unique case (prog)
          P_COF:   rd_addr = sub ? {r1, c2} : {r1, c1};
          P_DET:   rd_addr = {2'd0, t};
          P_TRN:   rd_addr = {t, 2'd3};
          default: rd_addr = '0;
        endcase
      end else begin
        rd_addr = sub ? {r2, c1} : {r2, c2};
      end
    end else if (state == S_CPY0) begin
      rd_addr = k;
    end
  end

  // determinant expands along row 0: element (0,t) times cofactor (t,0)
  always_comb begin
    cof_row = (state == S_MAC && prog == P_DET) ? t : k[3:2];
    cof_col = (state == S_MAC && prog == P_DET) ? 2'd0 : (state == S_MAC) ? t : k[1:0];
    if (cof_col == 2'd3) begin
      cof_addr = '0;
    end else begin
      cof_addr = 4'({cof_row, 1'b0}) + 4'(cof_row) + 4'(cof_col);
    end
    cof_rd = cof[cof_addr];
  end

  assign pext     = {{(ACC_W-66){p[65]}}, p};
  assign acc_base = clear ? '0 : acc;
  assign acc_next = p_neg ? acc_base - (p_sh ? pext << 32 : pext)
                          : acc_base + (p_sh ? pext << 32 : pext);

  assign tol = ACC_W'(cfg.det_tolerance) << (2 * FRAC_BITS);

  assign src = j3 ? acc : {{(ACC_W-COF_W){cof_rd[COF_W-1]}}, cof_rd};
  assign mag = src[ACC_W-1] ? '0 - src : src;

  assign r_sh  = {dr, dq[ACC_W-1]};
  assign r_ge  = (r_sh >= {1'b0, det_mag});
  assign limit = dneg ? ACC_W'(33'h0_8000_0000) : ACC_W'(33'h0_7FFF_FFFF);
  assign over  = (dq > limit);
  assign mag32 = over ? limit[VAL_W-1:0] : dq[VAL_W-1:0];

  assign q_ready   = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_data  = '{out_index: k, out_value: o_val, singular: singular,
                       saturated: o_sat, last_out: (k == LAST_INDEX)};

  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_valid) begin
      store[q_data.elem_index] <= q_data.elem_value;
    end
    rd_data <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      prog  <= P_COF;
      op    <= '0;
      ph    <= '0;
      k     <= '0;
      dcnt  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid && q_data.elem_index == LAST_INDEX) begin
            state <= S_MAC;
            prog  <= P_COF;
            op    <= '0;
            ph    <= '0;
          end
        end
        S_MAC: begin
          ph <= (ph == 3'd4) ? 3'd0 : ph + 3'd1;
          unique case (ph)
            3'd0: ;
            3'd1: opa <= rd_data;
            3'd2: begin
              if (prog == P_COF) begin
                opb <= {rd_data[VAL_W-1], rd_data};
              end else begin
                opb <= sub ? cof_rd[COF_W-1:VAL_W] : {1'b0, cof_rd[VAL_W-1:0]};
              end
              p_sh  <= (prog != P_COF) && sub;
              p_neg <= (prog == P_COF) && sub;
            end
            3'd3: p <= $signed({opa[VAL_W-1], opa}) * opb;
            default: begin
              acc <= acc_next;
              if (prog == P_COF && sub) begin
                cof[c] <= acc_next[COF_W-1:0];
              end
              if (!last_op) begin
                op <= op + 5'd1;
              end else begin
                op <= '0;
                unique case (prog)
                  P_COF: prog <= P_DET;
                  P_DET: begin
                    det   <= acc_next;
                    state <= S_CHK1;
                  end
                  default: state <= S_DLD;
                endcase
              end
            end
          endcase
        end
        S_CHK1: begin
          det_mag <= det[ACC_W-1] ? '0 - det : det;
          state   <= S_CHK2;
        end
        S_CHK2: begin
          singular <= (det_mag <= tol);
          k        <= '0;
          state    <= S_ELEM;
        end
        S_ELEM: begin
          if (singular) begin
            o_val <= '0;
            o_sat <= 1'b0;
            state <= S_OUT;
          end else if (!j3) begin
            state <= S_DLD;
          end else if (cfg.keep_translation) begin
            state <= S_CPY0;
          end else begin
            prog  <= P_TRN;
            op    <= '0;
            ph    <= '0;
            state <= S_MAC;
          end
        end
        S_CPY0: state <= S_CPY1;
        S_CPY1: begin
          o_val <= rd_data;
          o_sat <= 1'b0;
          state <= S_OUT;
        end
        S_DLD: begin
          dn    <= j3 ? mag << FRAC_BITS : mag << (2 * FRAC_BITS);
          dneg  <= (j3 ? (!acc[ACC_W-1] && acc != '0) : cof_rd[COF_W-1]) ^ det[ACC_W-1];
          state <= S_DADD;
        end
        S_DADD: begin
          dq    <= dn + (det_mag >> 1);
          dr    <= '0;
          dcnt  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          dr   <= r_ge ? ACC_W'(r_sh - {1'b0, det_mag}) : r_sh[ACC_W-1:0];
          dq   <= {dq[ACC_W-2:0], r_ge};
          dcnt <= dcnt + 1'b1;
          if (dcnt == DCNT_W'(ACC_W - 1)) begin
            state <= S_DSAT;
          end
        end
        S_DSAT: begin
          o_sat <= over;
          o_val <= dneg ? VAL_W'(0) - mag32 : mag32;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            if (k == LAST_INDEX) begin
              state <= S_IDLE;
            end else begin
              k     <= k + 1'b1;
              state <= S_ELEM;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/affine_3x4_inverse.sv
`timescale 1ns / 1ps
// affine_3x4_inverse: top level; configuration registers, front queue, back end.
// Depends on aff_inv_pkg, aff_inv_front, aff_inv_back.
//
//   channel | signals                          | transfer when
//   in      | in_valid, in_ready, in_data      | in_valid && in_ready
//   out     | out_valid, out_ready, out_data   | out_valid && out_ready
//   cfg     | cfg_valid, cfg_ready, cfg_index, | cfg_valid && cfg_ready
//           | cfg_data                         |
//
// Elements 0..10 pass through a four-entry queue into the element store.
// Element 11 starts a run: 24 MAC steps for cofactors and determinant, then per
// non-singular result a restoring divider, which copied translation elements
// skip (plus six MAC steps per translation element in full mode).
// Reset is synchronous; it clears control state and sets the registers.
// Each result waits in the output register until taken; input keeps queueing until the queue is full.
module affine_3x4_inverse import aff_inv_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  elem_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output elem_out_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TOL_W-1:0]     cfg_data
);

  cfg_t     cfg;
  logic     q_valid;
  logic     q_ready;
  elem_in_t q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.keep_translation <= 1'b0;
      cfg.det_tolerance    <= TOL_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_KEEP_TRANSLATION: cfg.keep_translation <= cfg_data[0];
        CFG_DET_TOLERANCE:    cfg.det_tolerance    <= cfg_data;
        default: ;
      endcase
    end
  end

  aff_inv_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_data   (q_data)
  );

  aff_inv_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: rtl/core/aff_inv_chk.sv
`timescale 1ns / 1ps
// aff_inv_chk: port-level checks on the result channel, bound to the top level.
// Depends on aff_inv_pkg and affine_3x4_inverse.
module aff_inv_chk import aff_inv_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_ready,
  input elem_out_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");

  a_singular: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.singular |-> out_data.out_value == '0 && !out_data.saturated)
    else $error("singular result not zero");

  a_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.saturated |->
      (out_data.out_value == 32'sh7FFF_FFFF || out_data.out_value == 32'sh8000_0000))
    else $error("saturated value not at a limit");

  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.last_out == (out_data.out_index == LAST_INDEX))
    else $error("last flag mismatch");

endmodule

bind affine_3x4_inverse aff_inv_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: tb/sv/affine_3x4_inverse_tb.sv
`timescale 1ns / 1ps
// affine_3x4_inverse_tb: self-checking bench for the 3x4 affine inverse block.
// Loads matrices element by element, predicts the twelve inverse elements in
// wide integer arithmetic and checks every output transfer. Needs aff_inv_pkg.
module affine_3x4_inverse_tb;
  import aff_inv_pkg::*;

  typedef logic signed [191:0] wide_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  elem_in_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  elem_out_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_KEEP_TRANSLATION;
  logic [TOL_W-1:0]     cfg_data = '0;

  logic signed [VAL_W-1:0] matrix_copy [NUM_ELEM];
  logic                    copy_translation = 1'b0;
  logic [TOL_W-1:0]        singular_tol = 16'd1;
  elem_out_t               inverse_q [$];
  int                      fail_count = 0;
  int                      items_sent = 0;
  bit                      sender_gaps = 1'b1;
  bit                      hold_request = 1'b0;

  affine_3x4_inverse u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  initial begin
    #30ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic wide_t m_at(int r, int c);
    return wide_t'(matrix_copy[r*4 + c]);
  endfunction

  // round half away from zero, clip to 32 bits
  function automatic logic [VAL_W-1:0] round_div(wide_t num, wide_t den, output logic sat);
    logic  neg;
    wide_t n, d, q, lim;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = (n + (d >>> 1)) / d;
    lim = neg ? wide_t'(64'h8000_0000) : wide_t'(64'h7FFF_FFFF);
    sat = 1'b0;
    if (q > lim) begin
      sat = 1'b1;
      q = lim;
    end
    return neg ? -q[VAL_W-1:0] : q[VAL_W-1:0];
  endfunction

  task automatic predict_inverse();
    wide_t     cof [3][3];
    wide_t     det, acc;
    logic      sing, sat;
    elem_out_t r;
    int        i, j;
    for (i = 0; i < 3; i++)
      for (j = 0; j < 3; j++)
        cof[i][j] = m_at((j+1)%3, (i+1)%3) * m_at((j+2)%3, (i+2)%3)
                  - m_at((j+1)%3, (i+2)%3) * m_at((j+2)%3, (i+1)%3);
    det = m_at(0,0)*cof[0][0] + m_at(0,1)*cof[1][0] + m_at(0,2)*cof[2][0];
    sing = ((det < 0) ? -det : det) <= (wide_t'(singular_tol) <<< 32);
    for (int k = 0; k < NUM_ELEM; k++) begin
      i = k / 4;
      j = k % 4;
      r = '0;
      r.out_index = IDX_W'(k);
      r.singular = sing;
      r.last_out = (k == NUM_ELEM - 1);
      sat = 1'b0;
      if (!sing) begin
        if (j < 3) begin
          r.out_value = round_div(cof[i][j] <<< 32, det, sat);
        end else if (copy_translation) begin
          r.out_value = matrix_copy[k];
        end else begin
          acc = cof[i][0]*m_at(0,3) + cof[i][1]*m_at(1,3) + cof[i][2]*m_at(2,3);
          r.out_value = round_div((-acc) <<< 16, det, sat);
        end
      end
      r.saturated = sat;
      inverse_q.push_back(r);
    end
  endtask

  task automatic send_elem(int idx, logic [VAL_W-1:0] val);
    int gap;
    in_valid <= 1'b1;
    in_data.elem_index <= IDX_W'(idx);
    in_data.elem_value <= val;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (idx < NUM_ELEM) begin
      matrix_copy[idx] = val;
      if (idx == NUM_ELEM - 1) predict_inverse();
    end
    gap = 0;
    if (sender_gaps) begin
      case ($urandom_range(9))
        0, 1, 2: gap = $urandom_range(1, 3);
        3:       gap = $urandom_range(6, 40);
        default: gap = 0;
      endcase
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    wait (inverse_q.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TOL_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_KEEP_TRANSLATION) copy_translation = val[0];
    else if (idx == CFG_DET_TOLERANCE) singular_tol = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_mode(logic keep, logic [TOL_W-1:0] tol);
    wait_idle();
    write_reg(CFG_KEEP_TRANSLATION, TOL_W'(keep));
    write_reg(CFG_DET_TOLERANCE, tol);
  endtask

  function automatic logic [VAL_W-1:0] pick_value(int kind);
    case (kind)
      0:       return VAL_W'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
      1:       return $urandom;
      2:       return VAL_W'($signed($urandom_range(0, 64)) - 32);
      default: return VAL_W'($signed($urandom_range(0, 1 << 23)) - (1 << 22));
    endcase
  endfunction

  // full load in random order with some noise, then the trigger element
  task automatic send_random_matrix();
    int order [11];
    int kind, t, j;
    kind = $urandom_range(4);
    for (int i = 0; i < 11; i++) order[i] = i;
    for (int i = 10; i > 0; i--) begin
      j = $urandom_range(i);
      t = order[i]; order[i] = order[j]; order[j] = t;
    end
    for (int i = 0; i < 11; i++) begin
      if ($urandom_range(15) == 0) send_elem($urandom_range(12, 15), $urandom);
      if (kind == 4 && order[i] >= 8) send_elem(order[i], matrix_copy[order[i] - 4]);
      else send_elem(order[i], pick_value(kind == 4 ? 0 : kind));
    end
    send_elem(11, pick_value(kind == 4 ? 0 : kind));
  endtask

  task automatic send_partial_update();
    int n;
    n = $urandom_range(1, 4);
    repeat (n) begin
      if ($urandom_range(3) == 0) send_elem($urandom_range(12, 15), $urandom);
      else send_elem($urandom_range(10), pick_value($urandom_range(3)));
    end
    send_elem(11, pick_value($urandom_range(3)));
  endtask

  task automatic test_identity();
    for (int k = 0; k < NUM_ELEM; k++)
      send_elem(k, (k % 5 == 0) ? 32'h0001_0000 : (k % 4 == 3) ? 32'h0002_8000 : 32'h0);
  endtask

  task automatic test_extremes();
    send_elem(0, 32'h0000_0001);
    send_elem(3, 32'h8000_0000);
    send_elem(7, 32'h7FFF_FFFF);
    send_elem(11, 32'hFFFF_FFFF);
  endtask

  task automatic test_ignored_and_singular();
    send_elem(12, 32'hFFFF_FFFF);
    send_elem(15, 32'h0000_0000);
    send_elem(0, 32'h0);
    send_elem(11, 32'h0001_0000);
  endtask

  task automatic test_copy_mode();
    set_mode(1'b1, 16'd0);
    send_elem(0, 32'h0000_8000);
    send_elem(11, 32'h8000_0000);
    send_elem(0, 32'h0);
    send_elem(11, 32'h7FFF_FFFF);
  endtask

  task automatic test_tolerance_limits();
    set_mode(1'b0, 16'hFFFF);
    send_elem(0, 32'h0001_0000);
    send_elem(11, 32'h0);
    send_elem(5, 32'h00FF_0000);
    send_elem(11, 32'h0);
  endtask

  task automatic test_backpressure();
    wait_idle();
    hold_request = 1'b1;
    sender_gaps = 1'b0;
    send_random_matrix();
    send_random_matrix();
    sender_gaps = 1'b1;
  endtask

  task automatic test_random();
    int phase;
    phase = 0;
    while (items_sent < 430) begin
      if (items_sent > 60 + phase * 70) begin
        phase++;
        case (phase % 4)
          0: set_mode(1'b0, 16'd1);
          1: set_mode(1'b1, 16'hFFFF);
          2: set_mode(1'b0, 16'd0);
          default: set_mode(1'($urandom_range(1)), TOL_W'($urandom_range(0, 16'hFFFF)));
        endcase
      end
      if ($urandom_range(2) == 0) send_partial_update();
      else send_random_matrix();
    end
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    int n;
    @(negedge rst);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (600) @(posedge clk);
      end else begin
        case ($urandom_range(9))
          0, 1:    begin out_ready <= 1'b0; n = $urandom_range(1, 3); end
          2:       begin out_ready <= 1'b0; n = $urandom_range(8, 60); end
          3:       begin out_ready <= 1'b1; n = $urandom_range(20, 80); end
          default: begin out_ready <= 1'b1; n = $urandom_range(1, 4); end
        endcase
        repeat (n) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    elem_out_t e;
    if (!rst && out_valid && out_ready) begin
      if (inverse_q.size() == 0) begin
        $error("unexpected result transfer index %0d", out_data.out_index);
        fail_count++;
      end else begin
        e = inverse_q.pop_front();
        if (out_data.out_index !== e.out_index) begin
          $error("out_index exp %0d got %0d", e.out_index, out_data.out_index);
          fail_count++;
        end
        if (out_data.out_value !== e.out_value) begin
          $error("out_value exp %h got %h", e.out_value, out_data.out_value);
          fail_count++;
        end
        if (out_data.singular !== e.singular) begin
          $error("singular exp %b got %b", e.singular, out_data.singular);
          fail_count++;
        end
        if (out_data.saturated !== e.saturated) begin
          $error("saturated exp %b got %b", e.saturated, out_data.saturated);
          fail_count++;
        end
        if (out_data.last_out !== e.last_out) begin
          $error("last_out exp %b got %b", e.last_out, out_data.last_out);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_identity();
    test_extremes();
    test_ignored_and_singular();
    test_copy_mode();
    test_tolerance_limits();
    test_backpressure();
    test_random();
    wait_idle();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/aff_inv_pkg.sv
rtl/core/aff_inv_front.sv
rtl/core/aff_inv_back.sv
rtl/core/affine_3x4_inverse.sv
rtl/core/aff_inv_chk.sv
tb/sv/affine_3x4_inverse_tb.sv
